// ===== design/owm_pkg.sv =====
// ----------------------------------------------------------------------------
// owm_pkg - shared types and constants of the 1-wire bus master
// Commands, phases, register indexes and the structs passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package owm_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_RST_LOW    = 3'd1,
    PH_RST_SAMPLE = 3'd2,
    PH_WRITE      = 3'd3,
    PH_READ       = 3'd4
  } phase_t;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] REG_RESET_PERIOD    = 3'd0;
  localparam logic [2:0] REG_PRESENCE_OFFSET = 3'd1;
  localparam logic [2:0] REG_SLOT_PERIOD     = 3'd2;
  localparam logic [2:0] REG_WRITE_ONE_LOW   = 3'd3;
  localparam logic [2:0] REG_READ_LOW        = 3'd4;
  localparam logic [2:0] REG_READ_OFFSET     = 3'd5;

  localparam logic [9:0] RESET_PERIOD_DEF    = 10'd486;
  localparam logic [9:0] PRESENCE_OFFSET_DEF = 10'd100;
  localparam logic [7:0] SLOT_PERIOD_DEF     = 8'd61;
  localparam logic [7:0] WRITE_ONE_LOW_DEF   = 8'd5;
  localparam logic [7:0] READ_LOW_DEF        = 8'd2;
  localparam logic [7:0] READ_OFFSET_DEF     = 8'd7;

  typedef struct packed {
    logic [9:0] reset_period;
    logic [9:0] presence_offset;
    logic [7:0] slot_period;
    logic [7:0] write_one_low;
    logic [7:0] read_low;
    logic [7:0] read_offset;
  } owm_cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
  } owm_res_t;

endpackage

`default_nettype wire

// ===== design/owm_in_if.sv =====
// ----------------------------------------------------------------------------
// owm_in_if - command channel of the 1-wire bus master
// Valid/ready channel carrying one command beat with its tick data.
// ----------------------------------------------------------------------------
`default_nettype none

interface owm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;
  logic       line_level;

  modport source (output valid, output command, output data_byte, output line_level,
                  input ready);
  modport sink   (input valid, input command, input data_byte, input line_level,
                  output ready);
endinterface

`default_nettype wire

// ===== design/owm_out_if.sv =====
// ----------------------------------------------------------------------------
// owm_out_if - result channel of the 1-wire bus master
// Valid/ready channel carrying one result beat per command beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface owm_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] read_data;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output presence, output read_data, input ready);
  modport sink   (input valid, input drive_low, input busy_res, input done_res,
                  input presence, input read_data, output ready);
endinterface

`default_nettype wire

// ===== design/owm_cfg.sv =====
// ----------------------------------------------------------------------------
// owm_cfg - timing registers of the 1-wire bus master
// APB-style register file holding the reset and slot timing values.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [owm_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [owm_pkg::DATA_W-1:0]   pwdata,
  output      logic [owm_pkg::DATA_W-1:0]   prdata,
  output      logic                         pready,
  output      owm_pkg::owm_cfg_t            cfg
);

  owm_pkg::owm_cfg_t cfg_r;
  owm_pkg::owm_cfg_t cfg_nxt;
  logic [2:0]        index;
  logic              wr_en;

  assign index  = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (index)
        owm_pkg::REG_RESET_PERIOD:    cfg_nxt.reset_period    = pwdata[9:0];
        owm_pkg::REG_PRESENCE_OFFSET: cfg_nxt.presence_offset = pwdata[9:0];
        owm_pkg::REG_SLOT_PERIOD:     cfg_nxt.slot_period     = pwdata[7:0];
        owm_pkg::REG_WRITE_ONE_LOW:   cfg_nxt.write_one_low   = pwdata[7:0];
        owm_pkg::REG_READ_LOW:        cfg_nxt.read_low        = pwdata[7:0];
        owm_pkg::REG_READ_OFFSET:     cfg_nxt.read_offset     = pwdata[7:0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      owm_pkg::REG_RESET_PERIOD:    prdata = {22'd0, cfg_r.reset_period};
      owm_pkg::REG_PRESENCE_OFFSET: prdata = {22'd0, cfg_r.presence_offset};
      owm_pkg::REG_SLOT_PERIOD:     prdata = {24'd0, cfg_r.slot_period};
      owm_pkg::REG_WRITE_ONE_LOW:   prdata = {24'd0, cfg_r.write_one_low};
      owm_pkg::REG_READ_LOW:        prdata = {24'd0, cfg_r.read_low};
      owm_pkg::REG_READ_OFFSET:     prdata = {24'd0, cfg_r.read_offset};
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_period    <= owm_pkg::RESET_PERIOD_DEF;
      cfg_r.presence_offset <= owm_pkg::PRESENCE_OFFSET_DEF;
      cfg_r.slot_period     <= owm_pkg::SLOT_PERIOD_DEF;
      cfg_r.write_one_low   <= owm_pkg::WRITE_ONE_LOW_DEF;
      cfg_r.read_low        <= owm_pkg::READ_LOW_DEF;
      cfg_r.read_offset     <= owm_pkg::READ_OFFSET_DEF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/owm_engine.sv =====
// ----------------------------------------------------------------------------
// owm_engine - phase sequencer of the 1-wire bus master
// Holds the operation state and advances it by one tick per accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [1:0]        command,
  input  wire logic [7:0]        data_byte,
  input  wire logic              line_level,
  input  wire owm_pkg::owm_cfg_t cfg,
  output      owm_pkg::owm_res_t res
);

  owm_pkg::phase_t phase_r, phase_nxt;
  logic [9:0]      tick_r, tick_nxt;
  logic [2:0]      bit_r, bit_nxt;
  logic [7:0]      shift_r, shift_nxt;
  logic            presence_r, presence_nxt;
  logic [7:0]      rdreg_r, rdreg_nxt;

  logic [9:0]      rst_last;
  logic [9:0]      rst_sample;
  logic [9:0]      slot_last;
  logic [7:0]      rd_late;
  logic [9:0]      rd_sample;

  // Timing limits: a zero period behaves as one, sample points clamp to the
  // last tick of their phase or slot.
  always_comb begin
    rst_last   = (cfg.reset_period == 10'd0) ? 10'd0 : cfg.reset_period - 10'd1;
    rst_sample = (cfg.presence_offset < rst_last) ? cfg.presence_offset : rst_last;
    slot_last  = {2'd0, (cfg.slot_period == 8'd0) ? 8'd0 : cfg.slot_period - 8'd1};
    rd_late    = (cfg.read_offset > cfg.read_low) ? cfg.read_offset : cfg.read_low;
    rd_sample  = ({2'd0, rd_late} > slot_last) ? slot_last : {2'd0, rd_late};
  end

  always_comb begin
    logic drive;
    logic done;
    logic [7:0] shift_s;
    drive        = 1'b0;
    done         = 1'b0;
    shift_s      = shift_r;
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    bit_nxt      = bit_r;
    shift_nxt    = shift_r;
    presence_nxt = presence_r;
    rdreg_nxt    = rdreg_r;

    unique case (phase_r)
      owm_pkg::PH_RST_LOW,
      owm_pkg::PH_RST_SAMPLE: begin
        drive = (phase_r == owm_pkg::PH_RST_LOW);
        if (phase_r == owm_pkg::PH_RST_SAMPLE && tick_r == rst_sample) begin
          presence_nxt = ~line_level;
        end
        if (tick_r >= rst_last) begin
          tick_nxt = '0;
          if (phase_r == owm_pkg::PH_RST_LOW) begin
            phase_nxt = owm_pkg::PH_RST_SAMPLE;
          end else begin
            phase_nxt = owm_pkg::PH_IDLE;
            done      = 1'b1;
          end
        end else begin
          tick_nxt = tick_r + 10'd1;
        end
      end
      owm_pkg::PH_WRITE,
      owm_pkg::PH_READ: begin
        if (phase_r == owm_pkg::PH_WRITE) begin
          drive = !shift_r[0] || (tick_r < {2'd0, cfg.write_one_low});
        end else begin
          drive = tick_r < {2'd0, cfg.read_low};
          if (tick_r == rd_sample) begin
            shift_s = {line_level, shift_r[7:1]};
          end
        end
        shift_nxt = shift_s;
        if (tick_r >= slot_last) begin
          tick_nxt = '0;
          if (phase_r == owm_pkg::PH_WRITE) begin
            shift_nxt = {1'b0, shift_r[7:1]};
          end
          if (bit_r == 3'd7) begin
            if (phase_r == owm_pkg::PH_READ) begin
              rdreg_nxt = shift_s;
            end
            bit_nxt   = '0;
            phase_nxt = owm_pkg::PH_IDLE;
            done      = 1'b1;
          end else begin
            bit_nxt = bit_r + 3'd1;
          end
        end else begin
          tick_nxt = tick_r + 10'd1;
        end
      end
      default: begin
        // Idle: a start command loads the operation without using a tick.
        phase_nxt = owm_pkg::PH_IDLE;
        if (command != owm_pkg::CMD_TICK) begin
          tick_nxt = '0;
          bit_nxt  = '0;
          unique case (command)
            owm_pkg::CMD_RESET: phase_nxt = owm_pkg::PH_RST_LOW;
            owm_pkg::CMD_WRITE: begin
              phase_nxt = owm_pkg::PH_WRITE;
              shift_nxt = data_byte;
            end
            default: begin
              phase_nxt = owm_pkg::PH_READ;
              shift_nxt = '0;
            end
          endcase
        end
      end
    endcase

    res.drive_low = drive;
    res.busy_res  = (phase_nxt != owm_pkg::PH_IDLE);
    res.done_res  = done;
    res.presence  = presence_nxt;
    res.read_data = rdreg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= owm_pkg::PH_IDLE;
      tick_r     <= '0;
      bit_r      <= '0;
      shift_r    <= '0;
      presence_r <= 1'b0;
      rdreg_r    <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      bit_r      <= bit_nxt;
      shift_r    <= shift_nxt;
      presence_r <= presence_nxt;
      rdreg_r    <= rdreg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/onewire_bus_master.sv =====
// Result timing: a result beat is valid in the cycle after its command beat is accepted.
// Throughput: one command beat per cycle; the result register lets the next beat
// in while the current result is being taken, so only a stalled result holds input.
// Reset: synchronous, active low; clears the phase, counters, flags and the result
// valid flag, and restores the timing registers to their defaults.
// ----------------------------------------------------------------------------
// onewire_bus_master - 1-wire bus master timed by microsecond ticks
// Runs reset/presence, write-byte and read-byte sequences one tick per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_bus_master (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  owm_in_if.sink                          in_ch,
  owm_out_if.source                       out_ch,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [owm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [owm_pkg::DATA_W-1:0] pwdata,
  output      logic [owm_pkg::DATA_W-1:0] prdata,
  output      logic                       pready
);

  owm_pkg::owm_cfg_t cfg;
  owm_pkg::owm_res_t res;
  owm_pkg::owm_res_t out_res_r;
  logic              out_valid_r, out_valid_nxt;
  logic              in_fire;

  owm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  owm_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_fire),
    .command    (in_ch.command),
    .data_byte  (in_ch.data_byte),
    .line_level (in_ch.line_level),
    .cfg        (cfg),
    .res        (res)
  );

  assign out_valid_nxt = in_fire || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.drive_low = out_res_r.drive_low;
  assign out_ch.busy_res  = out_res_r.busy_res;
  assign out_ch.done_res  = out_res_r.done_res;
  assign out_ch.presence  = out_res_r.presence;
  assign out_ch.read_data = out_res_r.read_data;

endmodule

`default_nettype wire

// ===== design/owm_checker.sv =====
// ----------------------------------------------------------------------------
// owm_checker - port-level checks for the 1-wire bus master
// Watches the command and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       busy_res,
  input wire logic       done_res,
  input wire logic [7:0] read_data
);

  // A held result beat keeps its payload until taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(busy_res) && $stable(done_res)
      && $stable(read_data))
    else $error("result beat changed while stalled");

  // The block never refuses a beat while its result slot is free.
  assert property (@(posedge clk) !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Every accepted beat produces a result beat in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat produced no result");

  // An operation that completes has left the busy state.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  // After reset no result beat is offered.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind onewire_bus_master owm_checker u_owm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .busy_res  (out_ch.busy_res),
  .done_res  (out_ch.done_res),
  .read_data (out_ch.read_data)
);

`default_nettype wire
